// ===== hw/rtl/rnm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rnm_pkg;

    localparam int NODES_DEF = 64;

    localparam int KIND_W  = 3;
    localparam int SLOT_W  = 6;
    localparam int TASK_W  = 32;
    localparam int COUNT_W = 7;

    localparam logic [KIND_W-1:0] K_INIT    = 3'd0;
    localparam logic [KIND_W-1:0] K_RECORD  = 3'd1;
    localparam logic [KIND_W-1:0] K_STOP    = 3'd2;
    localparam logic [KIND_W-1:0] K_RESTART = 3'd3;
    localparam logic [KIND_W-1:0] K_FIND    = 3'd4;

    localparam logic [KIND_W-1:0] RK_DONE     = 3'd0;
    localparam logic [KIND_W-1:0] RK_NOTICE   = 3'd1;
    localparam logic [KIND_W-1:0] RK_FOUND    = 3'd2;
    localparam logic [KIND_W-1:0] RK_NOTFOUND = 3'd3;
    localparam logic [KIND_W-1:0] RK_REJECT   = 3'd4;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] node_index;
        logic [TASK_W-1:0] task_id;
    } t_ring_item;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [TASK_W-1:0] dest_task;
        logic [TASK_W-1:0] sibling_task;
        logic [SLOT_W-1:0] found_index;
        logic              last;
    } t_ring_result;

endpackage

`default_nettype wire

// ===== hw/rtl/node_ring_membership_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ring membership engine for a set of worker slots.
// An item is taken when start is high and busy is low; busy is low in the cycle
// the last result of that item is shown. Results appear on o_result for exactly
// one cycle each, marked by o_valid; the receiver cannot stall them.
// The configuration channel (i_cfg_valid, o_cfg_ready, i_cfg_data) sets the number
// of active slots; it is always ready and should only be written while idle.
// What each item does, from acceptance to the last result:
//   record or rejected at acceptance: result issued straight from idle
//   init: one link table entry written per cycle
//   find: one task table read per cycle
//   stop: states S_ST_A, S_ST_B, S_ST_C; rejected when the slot is already dead
//   restart: includes the scan for a live partner; rejected when
//   the slot is live.
// A restart with a live partner gives two results in consecutive cycles.
// Throughput is bounded by the single read port of each table: one item at a time.
// Reset sets the slot count to 1 and returns to idle; table contents are
// undefined until an init item and record items have written them.

module node_ring_membership_core #(
    parameter int NODES = rnm_pkg::NODES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               start,
    output logic                                    busy,
    input  wire rnm_pkg::t_ring_item                i_item,
    output logic                                    o_valid,
    output rnm_pkg::t_ring_result                   o_result,
    input  wire logic                               i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  wire logic [rnm_pkg::COUNT_W-1:0]        i_cfg_data
);

    import rnm_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam int CW = $clog2(NODES + 1);
    localparam int NW = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int LW = 2 * IW + 1;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_INIT    = 4'd1;
    localparam logic [3:0] S_FIND    = 4'd2;
    localparam logic [3:0] S_ST_A    = 4'd3;
    localparam logic [3:0] S_ST_B    = 4'd4;
    localparam logic [3:0] S_ST_C    = 4'd5;
    localparam logic [3:0] S_RS_CHK  = 4'd6;
    localparam logic [3:0] S_RS_SCAN = 4'd7;
    localparam logic [3:0] S_RS_A    = 4'd8;
    localparam logic [3:0] S_RS_B    = 4'd9;
    localparam logic [3:0] S_RS_C    = 4'd10;
    localparam logic [3:0] S_RS_SOLO = 4'd11;

    function automatic t_ring_result mk_result(
        input logic [KIND_W-1:0] rk,
        input logic [TASK_W-1:0] dest,
        input logic [TASK_W-1:0] sib,
        input logic [SLOT_W-1:0] idx,
        input logic              lst
    );
        t_ring_result res;
        res.result_kind  = rk;
        res.dest_task    = dest;
        res.sibling_task = sib;
        res.found_index  = idx;
        res.last         = lst;
        return res;
    endfunction

    function automatic logic [LW-1:0] mk_link(
        input logic [IW-1:0] succ,
        input logic [IW-1:0] pred,
        input logic          dead
    );
        return {succ, pred, dead};
    endfunction

    logic [3:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_node_count;
    logic [IW-1:0]      r_slot, n_slot;
    logic [TASK_W-1:0]  r_tid, n_tid;
    logic [CW-1:0]      r_idx, n_idx;
    logic               r_pend, n_pend;
    logic [IW-1:0]      r_pidx, n_pidx;
    logic [IW-1:0]      r_nxt, n_nxt;
    logic [IW-1:0]      r_prv, n_prv;
    logic [IW-1:0]      r_part, n_part;
    logic [TASK_W-1:0]  r_dest, n_dest;
    logic [TASK_W-1:0]  r_sib, n_sib;
    logic               r_ovalid, n_ovalid;
    t_ring_result       r_out, n_out;

    logic               link_we;
    logic [IW-1:0]      link_waddr;
    logic [LW-1:0]      link_wdata;
    logic [IW-1:0]      link_raddr;
    logic [LW-1:0]      link_rdata;
    logic               task_we;
    logic [IW-1:0]      task_waddr;
    logic [TASK_W-1:0]  task_wdata;
    logic [IW-1:0]      task_raddr;
    logic [TASK_W-1:0]  task_rdata;

    logic [NW-1:0]      w_nc;
    logic [CW-1:0]      w_cnt;
    logic [CW-1:0]      w_cnt_dec;
    logic [CW-1:0]      w_idx_inc;
    logic [CW-1:0]      w_idx_dec;
    logic               w_slot_bad;
    logic [IW-1:0]      w_in_slot;
    logic [IW-1:0]      rd_succ;
    logic [IW-1:0]      rd_pred;
    logic               rd_dead;

    rnm_ram #(.WIDTH(LW), .DEPTH(NODES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    rnm_ram #(.WIDTH(TASK_W), .DEPTH(NODES)) u_task_ram (
        .i_clk   (i_clk),
        .i_we    (task_we),
        .i_waddr (task_waddr),
        .i_wdata (task_wdata),
        .i_raddr (task_raddr),
        .o_rdata (task_rdata)
    );

    assign w_nc = NW'(r_node_count);
    always_comb begin
        if (w_nc == '0) begin
            w_cnt = CW'(1);
        end else if (w_nc > NW'(NODES)) begin
            w_cnt = CW'(NODES);
        end else begin
            w_cnt = CW'(w_nc);
        end
    end

    assign w_cnt_dec  = w_cnt - 1'b1;
    assign w_idx_inc  = r_idx + 1'b1;
    assign w_idx_dec  = r_idx - 1'b1;
    assign w_slot_bad = NW'(i_item.node_index) >= NW'(w_cnt);
    assign w_in_slot  = IW'(i_item.node_index);

    assign rd_succ = link_rdata[2*IW:IW+1];
    assign rd_pred = link_rdata[IW:1];
    assign rd_dead = link_rdata[0];

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_tid      = r_tid;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pidx     = r_pidx;
        n_nxt      = r_nxt;
        n_prv      = r_prv;
        n_part     = r_part;
        n_dest     = r_dest;
        n_sib      = r_sib;
        n_ovalid   = 1'b0;
        n_out      = r_out;
        link_we    = 1'b0;
        link_waddr = '0;
        link_wdata = '0;
        link_raddr = '0;
        task_we    = 1'b0;
        task_waddr = '0;
        task_wdata = '0;
        task_raddr = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_slot = w_in_slot;
                    n_tid  = i_item.task_id;
                    n_idx  = '0;
                    n_pend = 1'b0;
                    if (i_item.kind == K_INIT) begin
                        n_state = S_INIT;
                    end else if (i_item.kind == K_FIND) begin
                        n_state = S_FIND;
                    end else if ((i_item.kind > K_FIND) || w_slot_bad) begin
                        n_ovalid = 1'b1;
                        n_out    = mk_result(RK_REJECT, '0, '0, '0, 1'b1);
                    end else if (i_item.kind == K_RECORD) begin
                        task_we    = 1'b1;
                        task_waddr = w_in_slot;
                        task_wdata = i_item.task_id;
                        n_ovalid   = 1'b1;
                        n_out      = mk_result(RK_DONE, '0, '0, '0, 1'b1);
                    end else if (i_item.kind == K_STOP) begin
                        link_raddr = w_in_slot;
                        n_state    = S_ST_A;
                    end else begin
                        link_raddr = w_in_slot;
                        n_state    = S_RS_CHK;
                    end
                end
            end
            S_INIT: begin
                link_we    = 1'b1;
                link_waddr = r_idx[IW-1:0];
                link_wdata = mk_link(
                    (w_idx_inc < w_cnt) ? w_idx_inc[IW-1:0] : '0,
                    (r_idx != '0) ? w_idx_dec[IW-1:0] : w_cnt_dec[IW-1:0],
                    1'b0);
                n_idx = w_idx_inc;
                if (r_idx == w_cnt_dec) begin
                    n_ovalid = 1'b1;
                    n_out    = mk_result(RK_DONE, '0, '0, '0, 1'b1);
                    n_state  = S_IDLE;
                end
            end
            S_FIND: begin
                if (r_idx != w_cnt) begin
                    task_raddr = r_idx[IW-1:0];
                    n_idx      = w_idx_inc;
                    n_pend     = 1'b1;
                    n_pidx     = r_idx[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && (task_rdata == r_tid)) begin
                    n_ovalid = 1'b1;
                    n_out    = mk_result(RK_FOUND, '0, '0, SLOT_W'(r_pidx), 1'b1);
                    n_state  = S_IDLE;
                end else if (r_idx == w_cnt) begin
                    n_ovalid = 1'b1;
                    n_out    = mk_result(RK_NOTFOUND, '0, '0, '0, 1'b1);
                    n_state  = S_IDLE;
                end
            end
            S_ST_A: begin
                if (rd_dead) begin
                    n_ovalid = 1'b1;
                    n_out    = mk_result(RK_REJECT, '0, '0, '0, 1'b1);
                    n_state  = S_IDLE;
                end else begin
                    link_we    = 1'b1;
                    link_waddr = r_slot;
                    link_wdata = mk_link(rd_succ, rd_pred, 1'b1);
                    link_raddr = rd_succ;
                    task_raddr = rd_pred;
                    n_nxt      = rd_succ;
                    n_prv      = rd_pred;
                    n_state    = S_ST_B;
                end
            end
            S_ST_B: begin
                link_we    = 1'b1;
                link_waddr = r_nxt;
                link_wdata = mk_link(rd_succ, r_prv, rd_dead);
                link_raddr = r_prv;
                task_raddr = r_nxt;
                n_dest     = task_rdata;
                n_state    = S_ST_C;
            end
            S_ST_C: begin
                link_we    = 1'b1;
                link_waddr = r_prv;
                link_wdata = mk_link(r_nxt, rd_pred, rd_dead);
                n_ovalid   = 1'b1;
                n_out      = mk_result(RK_NOTICE, r_dest, task_rdata, '0, 1'b1);
                n_state    = S_IDLE;
            end
            S_RS_CHK: begin
                if (!rd_dead) begin
                    n_ovalid = 1'b1;
                    n_out    = mk_result(RK_REJECT, '0, '0, '0, 1'b1);
                    n_state  = S_IDLE;
                end else begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_state = S_RS_SCAN;
                end
            end
            S_RS_SCAN: begin
                if (r_idx != w_cnt) begin
                    link_raddr = r_idx[IW-1:0];
                    n_idx      = w_idx_inc;
                    n_pend     = 1'b1;
                    n_pidx     = r_idx[IW-1:0];
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend && !rd_dead) begin
                    link_we    = 1'b1;
                    link_waddr = r_pidx;
                    link_wdata = mk_link(r_slot, rd_pred, 1'b0);
                    link_raddr = rd_succ;
                    task_raddr = r_pidx;
                    n_part     = r_pidx;
                    n_nxt      = rd_succ;
                    n_state    = S_RS_A;
                end else if (r_idx == w_cnt) begin
                    link_we    = 1'b1;
                    link_waddr = r_slot;
                    link_wdata = mk_link(r_slot, r_slot, 1'b0);
                    task_raddr = r_slot;
                    n_state    = S_RS_SOLO;
                end
            end
            S_RS_A: begin
                link_we    = 1'b1;
                link_waddr = r_nxt;
                link_wdata = mk_link(rd_succ, r_slot, rd_dead);
                task_raddr = r_slot;
                n_dest     = task_rdata;
                n_state    = S_RS_B;
            end
            S_RS_B: begin
                link_we    = 1'b1;
                link_waddr = r_slot;
                link_wdata = mk_link(r_nxt, r_part, 1'b0);
                task_raddr = r_nxt;
                n_sib      = task_rdata;
                n_ovalid   = 1'b1;
                n_out      = mk_result(RK_NOTICE, r_dest, task_rdata, '0, 1'b0);
                n_state    = S_RS_C;
            end
            S_RS_C: begin
                n_ovalid = 1'b1;
                n_out    = mk_result(RK_NOTICE, r_sib, task_rdata, '0, 1'b1);
                n_state  = S_IDLE;
            end
            S_RS_SOLO: begin
                n_ovalid = 1'b1;
                n_out    = mk_result(RK_NOTICE, task_rdata, task_rdata, '0, 1'b1);
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_node_count <= COUNT_W'(1);
            r_pend       <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_pend   <= n_pend;
            if (i_cfg_valid && o_cfg_ready) begin
                r_node_count <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
        r_tid  <= n_tid;
        r_idx  <= n_idx;
        r_pidx <= n_pidx;
        r_nxt  <= n_nxt;
        r_prv  <= n_prv;
        r_part <= n_part;
        r_dest <= n_dest;
        r_sib  <= n_sib;
        r_out  <= n_out;
    end

    assign busy        = (r_state != S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

// ===== hw/rtl/rnm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module rnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read of the entry being written returns the new data.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_we && (i_waddr == i_raddr)) begin
            r_rdata <= i_wdata;
        end else begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== sim/node_ring_membership_core_tb.sv =====
`timescale 1ns / 1ps

module node_ring_membership_core_tb;
    import rnm_pkg::*;

    localparam int SLOTS = NODES_DEF;
    localparam int CYCLE_LIMIT = 1000000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_ring_item i_item = '0;
    logic o_valid;
    t_ring_result o_result;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [COUNT_W-1:0] i_cfg_data = '0;

    node_ring_membership_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted ring state.
    logic [SLOT_W-1:0]  ring_next [SLOTS];
    logic [SLOT_W-1:0]  ring_prev [SLOTS];
    bit                 ring_dead [SLOTS];
    logic [TASK_W-1:0]  ring_task [SLOTS];
    logic [COUNT_W-1:0] ring_count = 7'd1;

    // Stimulus-side bookkeeping, used only to keep the item stream legal and meaningful.
    bit                 gen_task_set [SLOTS];
    bit                 gen_dead [SLOTS];
    bit                 gen_ring_ready = 1'b0;
    int                 gen_cnt = 1;
    logic [TASK_W-1:0]  tid_pool [8];

    t_ring_item   pending_items [$];
    t_ring_result expected_results [$];

    int pushed_items = 0;
    int accepted_items = 0;
    int results_checked = 0;
    int mismatches = 0;
    int notices_seen = 0;
    int finds_hit = 0;
    int rejects_seen = 0;
    int settings_run = 0;
    int idle_pct = 0;
    int cycle_count = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, expected_results.size());
            $display("** node_ring_membership_core: FAILED **");
            $finish;
        end
    end

    function automatic int clamp_count(input logic [COUNT_W-1:0] value);
        int c;
        c = int'(value);
        if (c < 1) c = 1;
        if (c > SLOTS) c = SLOTS;
        return c;
    endfunction

    function automatic void add_result(input logic [KIND_W-1:0] kind,
                                       input logic [TASK_W-1:0] dest,
                                       input logic [TASK_W-1:0] sib,
                                       input logic [SLOT_W-1:0] idx,
                                       input logic last);
        t_ring_result r;
        r.result_kind = kind;
        r.dest_task = dest;
        r.sibling_task = sib;
        r.found_index = idx;
        r.last = last;
        expected_results.push_back(r);
    endfunction

    function automatic void add_notice(input logic [SLOT_W-1:0] slot, input logic last);
        add_result(RK_NOTICE, ring_task[slot], ring_task[ring_next[slot]], '0, last);
    endfunction

    function automatic void predict_ring(input t_ring_item it);
        int cnt;
        int c;
        int partner;
        logic [SLOT_W-1:0] s;
        logic [SLOT_W-1:0] nx;
        logic [SLOT_W-1:0] pv;
        cnt = clamp_count(ring_count);
        s = it.node_index;
        if (it.kind == K_INIT) begin
            for (c = 0; c < cnt; c++) begin
                ring_next[c] = (c + 1 < cnt) ? SLOT_W'(c + 1) : '0;
                ring_prev[c] = (c > 0) ? SLOT_W'(c - 1) : SLOT_W'(cnt - 1);
                ring_dead[c] = 1'b0;
            end
            add_result(RK_DONE, '0, '0, '0, 1'b1);
        end else if (it.kind == K_FIND) begin
            partner = -1;
            for (c = 0; c < cnt && partner < 0; c++) begin
                if (ring_task[c] == it.task_id) partner = c;
            end
            if (partner >= 0) add_result(RK_FOUND, '0, '0, SLOT_W'(partner), 1'b1);
            else add_result(RK_NOTFOUND, '0, '0, '0, 1'b1);
        end else if (it.kind > K_FIND || int'(s) >= cnt) begin
            add_result(RK_REJECT, '0, '0, '0, 1'b1);
        end else if (it.kind == K_RECORD) begin
            ring_task[s] = it.task_id;
            add_result(RK_DONE, '0, '0, '0, 1'b1);
        end else if (it.kind == K_STOP) begin
            if (ring_dead[s]) begin
                add_result(RK_REJECT, '0, '0, '0, 1'b1);
            end else begin
                nx = ring_next[s];
                pv = ring_prev[s];
                ring_prev[nx] = pv;
                ring_next[pv] = nx;
                ring_dead[s] = 1'b1;
                add_notice(pv, 1'b1);
            end
        end else if (!ring_dead[s]) begin
            add_result(RK_REJECT, '0, '0, '0, 1'b1);
        end else begin
            partner = -1;
            for (c = 0; c < cnt && partner < 0; c++) begin
                if (!ring_dead[c]) partner = c;
            end
            if (partner < 0) begin
                ring_next[s] = s;
                ring_prev[s] = s;
                ring_dead[s] = 1'b0;
                add_notice(s, 1'b1);
            end else begin
                nx = ring_next[partner];
                ring_next[s] = nx;
                ring_prev[s] = SLOT_W'(partner);
                ring_dead[s] = 1'b0;
                ring_next[partner] = s;
                ring_prev[nx] = s;
                add_notice(SLOT_W'(partner), 1'b0);
                add_notice(s, 1'b1);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_ring(i_item);
                accepted_items <= accepted_items + 1;
            end
            if (!start || !busy) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    start <= 1'b1;
                    i_item <= pending_items.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_ring_result want;
        if (i_rst_n && o_valid === 1'b1) begin
            results_checked <= results_checked + 1;
            if (expected_results.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected result kind=%0d dest=%h sib=%h idx=%0d last=%0b",
                             $realtime, o_result.result_kind, o_result.dest_task,
                             o_result.sibling_task, o_result.found_index, o_result.last);
                end
                mismatches <= mismatches + 1;
            end else begin
                want = expected_results.pop_front();
                if (want.result_kind == RK_NOTICE) notices_seen <= notices_seen + 1;
                if (want.result_kind == RK_FOUND) finds_hit <= finds_hit + 1;
                if (want.result_kind == RK_REJECT) rejects_seen <= rejects_seen + 1;
                if (o_result.result_kind !== want.result_kind
                        || o_result.dest_task !== want.dest_task
                        || o_result.sibling_task !== want.sibling_task
                        || o_result.found_index !== want.found_index
                        || o_result.last !== want.last) begin
                    if (mismatches < 10) begin
                        $display("%0t: expected kind=%0d dest=%h sib=%h idx=%0d last=%0b",
                                 $realtime, want.result_kind, want.dest_task,
                                 want.sibling_task, want.found_index, want.last);
                        $display("%0t:      got kind=%0d dest=%h sib=%h idx=%0d last=%0b",
                                 $realtime, o_result.result_kind, o_result.dest_task,
                                 o_result.sibling_task, o_result.found_index, o_result.last);
                    end
                    mismatches <= mismatches + 1;
                end
            end
        end
    end

    function automatic void queue_item(input logic [KIND_W-1:0] kind,
                                       input logic [SLOT_W-1:0] slot,
                                       input logic [TASK_W-1:0] tid);
        t_ring_item it;
        int c;
        it.kind = kind;
        it.node_index = slot;
        it.task_id = tid;
        pending_items.push_back(it);
        pushed_items++;
        if (kind == K_INIT) begin
            for (c = 0; c < gen_cnt; c++) gen_dead[c] = 1'b0;
            gen_ring_ready = 1'b1;
        end else if (int'(slot) < gen_cnt) begin
            if (kind == K_RECORD) gen_task_set[slot] = 1'b1;
            if (kind == K_STOP) gen_dead[slot] = 1'b1;
            if (kind == K_RESTART) gen_dead[slot] = 1'b0;
        end
    endfunction

    function automatic bit all_tasks_set();
        int c;
        for (c = 0; c < gen_cnt; c++) begin
            if (!gen_task_set[c]) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [TASK_W-1:0] pick_tid();
        if ($urandom_range(99) < 70) return tid_pool[$urandom_range(7)];
        return $urandom;
    endfunction

    function automatic logic [SLOT_W-1:0] pick_slot(input bit want_dead);
        int offset;
        int c;
        int s;
        offset = $urandom_range(gen_cnt - 1);
        for (c = 0; c < gen_cnt; c++) begin
            s = (offset + c) % gen_cnt;
            if (gen_dead[s] == want_dead) return SLOT_W'(s);
        end
        return SLOT_W'(offset);
    endfunction

    function automatic void fill_random_phase(input int n);
        int i;
        int r;
        int c;
        logic [KIND_W-1:0] kind;
        logic [SLOT_W-1:0] slot;
        logic [TASK_W-1:0] tid;
        queue_item(K_INIT, SLOT_W'($urandom), $urandom);
        for (i = 0; i < n; i++) begin
            r = $urandom_range(99);
            slot = SLOT_W'($urandom_range(63));
            if ($urandom_range(99) < 85) slot = SLOT_W'($urandom_range(gen_cnt - 1));
            tid = pick_tid();
            if (r < 4) begin
                kind = K_INIT;
            end else if (r < 22) begin
                kind = K_RECORD;
            end else if (r < 47) begin
                kind = K_STOP;
                if ($urandom_range(99) < 85) slot = pick_slot(1'b0);
            end else if (r < 72) begin
                kind = K_RESTART;
                if ($urandom_range(99) < 85) slot = pick_slot(1'b1);
            end else if (r < 92) begin
                kind = K_FIND;
            end else begin
                kind = KIND_W'($urandom_range(7, 5));
            end
            // Never let the block read a table entry that nothing has written yet.
            if ((kind == K_FIND && !all_tasks_set())
                    || ((kind == K_STOP || kind == K_RESTART) && int'(slot) < gen_cnt
                        && !(gen_ring_ready && all_tasks_set()))) begin
                if (!all_tasks_set()) begin
                    kind = K_RECORD;
                    for (c = gen_cnt - 1; c >= 0; c--) begin
                        if (!gen_task_set[c]) slot = SLOT_W'(c);
                    end
                end else begin
                    kind = K_INIT;
                end
            end
            queue_item(kind, slot, tid);
        end
    endfunction

    task automatic wait_ring_idle();
        while (accepted_items != pushed_items || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_slot_count(input logic [COUNT_W-1:0] value);
        wait_ring_idle();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        ring_count = value;
        gen_cnt = clamp_count(value);
        gen_ring_ready = 1'b0;
        settings_run++;
    endtask

    initial begin
        logic [COUNT_W-1:0] settings [12];
        int p;
        settings = '{7'd64, 7'd1, 7'd0, 7'd2, 7'd127, 7'd7, 7'd33,
                     7'd64, 7'd3, 7'd17, 7'd64, 7'd5};
        tid_pool[0] = 32'h0000_0000;
        tid_pool[1] = 32'hFFFF_FFFF;
        for (p = 2; p < 8; p++) tid_pool[p] = $urandom;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        write_slot_count(7'd4);
        queue_item(K_INIT, '0, '0);
        queue_item(K_RECORD, 6'd0, 32'h0000_0000);
        queue_item(K_RECORD, 6'd1, 32'hFFFF_FFFF);
        queue_item(K_RECORD, 6'd2, 32'h1234_5678);
        queue_item(K_RECORD, 6'd3, 32'hA5A5_A5A5);
        queue_item(K_RECORD, 6'd63, 32'h5A5A_5A5A);
        queue_item(K_FIND, '0, 32'hFFFF_FFFF);
        queue_item(K_FIND, '0, 32'hDEAD_BEEF);
        queue_item(3'd5, 6'd1, 32'h1234_5678);
        queue_item(3'd6, 6'd2, '0);
        queue_item(3'd7, 6'd63, 32'hFFFF_FFFF);
        queue_item(K_STOP, 6'd1, '0);
        queue_item(K_STOP, 6'd1, '0);
        queue_item(K_RESTART, 6'd2, '0);
        queue_item(K_RESTART, 6'd1, '0);
        queue_item(K_STOP, 6'd0, '0);
        queue_item(K_STOP, 6'd1, '0);
        queue_item(K_STOP, 6'd2, '0);
        queue_item(K_STOP, 6'd3, '0);
        queue_item(K_RESTART, 6'd3, '0);
        queue_item(K_RESTART, 6'd0, '0);
        queue_item(K_FIND, '0, 32'h0000_0000);
        queue_item(K_STOP, 6'd63, '0);
        queue_item(K_RESTART, 6'd4, '0);
        queue_item(K_INIT, '0, '0);

        for (p = 0; p < 12; p++) begin
            write_slot_count(settings[p]);
            case (p % 4)
                0: idle_pct = 0;
                1: idle_pct = 77;
                2: idle_pct = 19;
                default: idle_pct = 0;
            endcase
            fill_random_phase(118);
        end

        wait_ring_idle();
        repeat (80) @(posedge i_clk);
        $display("Ran %0d items through %0d slot-count settings, checking %0d results.",
                 accepted_items, settings_run, results_checked);
        $display("Results included %0d sibling notices, %0d find hits and %0d rejections.",
                 notices_seen, finds_hit, rejects_seen);
        if (mismatches == 0) begin
            $display("** node_ring_membership_core: PASSED **");
        end else begin
            $display("%0d mismatches.", mismatches);
            $display("** node_ring_membership_core: FAILED **");
        end
        $finish;
    end

endmodule
